// File: hdl/hesm_pkg.sv
package hesm_pkg;

   localparam int ENTRY_BYTES = 256;
   localparam int RING_BYTES  = 256;
   localparam logic [8:0] HOST_MAX = 9'd253;
   localparam logic [7:0] DOT = 8'h2E;
   localparam int QDEPTH = 4;

   typedef enum logic [1:0] {
      OP_PAT_BYTE,
      OP_PAT_END,
      OP_NAME_BYTE,
      OP_NAME_END
   } op_type;

   typedef enum logic [1:0] {
      OUT_ADDED    = 2'd0,
      OUT_REJECTED = 2'd1,
      OUT_MISS     = 2'd2,
      OUT_HIT      = 2'd3
   } outcome_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_ADD_FIN,
      B_META_RD,
      B_META_CHK,
      B_CMP,
      B_EMIT
   } back_state_type;

   typedef struct packed {
      logic       valid;
      op_type     op;
      logic [7:0] text_byte;
   } queue_item_type;

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'h20;
      end
      return c;
   endfunction

endpackage

// File: hdl/hesm_if.sv
interface hesm_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] text_byte;
   logic       is_last;
   modport source(output valid, mode, text_byte, is_last, input ready);
   modport sink(input valid, mode, text_byte, is_last, output ready);
endinterface

interface hesm_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] outcome;
   logic [4:0] entries_held;
   modport source(output valid, outcome, entries_held, input ready);
   modport sink(input valid, outcome, entries_held, output ready);
endinterface

// File: hdl/host_exact_suffix_matcher_unit.sv
// Channel   Direction  Payload                          Handshake
// req_if    in         mode, text_byte, is_last         valid/ready
// rsp_if    out        outcome, entries_held            valid/ready
//
// A non-final request byte is consumed by the back end in its idle state.
// A final pattern request goes through B_ADD_FIN and B_EMIT before its response is shown.
// A final name request walks the stored entries: a metadata read and check
// per entry, then a byte compare when the entry's length suits the name, up to
// the entry length, over the pattern store and name ring read ports.
// Reset is synchronous and active high; no clearing pass is needed.
// A four-deep request queue lets intake continue while a response waits.
module host_exact_suffix_matcher_unit #(
   parameter int MAX_ENTRIES = 16
) (
   input logic         clock,
   input logic         reset,
   hesm_req_if.sink    req_if,
   hesm_rsp_if.source  rsp_if
);

   // Queue head handed from the intake side to the execution side.
   hesm_pkg::queue_item_type head;
   logic pop;

   // The front end classifies each request by mode and end mark and queues it.
   hesm_front u_front (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .pop(pop),
      .head(head)
   );

   // The back end stores bytes, closes patterns and walks the table on names.
   hesm_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
      .clock(clock),
      .reset(reset),
      .head(head),
      .pop(pop),
      .rsp_if(rsp_if)
   );

endmodule

// File: hdl/hesm_ram.sv
module hesm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/hesm_front.sv
module hesm_front (
   input  logic                     clock,
   input  logic                     reset,
   hesm_req_if.sink                 req_if,
   input  logic                     pop,
   output hesm_pkg::queue_item_type head
);

   localparam int PW = $clog2(hesm_pkg::QDEPTH);
   localparam int CNW = $clog2(hesm_pkg::QDEPTH + 1);

   hesm_pkg::op_type  op_mem_ff   [hesm_pkg::QDEPTH];
   logic [7:0]        byte_mem_ff [hesm_pkg::QDEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNW-1:0]    cnt_ff, cnt_in;
   hesm_pkg::op_type  op_class;
   logic              push, take;

   // Classify the request by mode and end mark.
   always_comb begin
      if (req_if.mode) begin
         op_class = req_if.is_last ? hesm_pkg::OP_NAME_END : hesm_pkg::OP_NAME_BYTE;
      end else begin
         op_class = req_if.is_last ? hesm_pkg::OP_PAT_END : hesm_pkg::OP_PAT_BYTE;
      end
   end

   assign req_if.ready = (cnt_ff != CNW'(hesm_pkg::QDEPTH));
   assign push = req_if.valid && req_if.ready;
   assign take = pop && (cnt_ff != '0);

   always_comb begin
      wr_ptr_in = push ? PW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = take ? PW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      cnt_in = cnt_ff;
      if (push && !take) begin
         cnt_in = CNW'(cnt_ff + 1'b1);
      end else if (take && !push) begin
         cnt_in = CNW'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         op_mem_ff[wr_ptr_ff] <= op_class;
         byte_mem_ff[wr_ptr_ff] <= req_if.text_byte;
      end
   end

   always_comb begin
      head.valid = (cnt_ff != '0);
      head.op = op_mem_ff[rd_ptr_ff];
      head.text_byte = byte_mem_ff[rd_ptr_ff];
   end

endmodule

// File: hdl/hesm_back.sv
module hesm_back #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  hesm_pkg::queue_item_type head,
   output logic                     pop,
   hesm_rsp_if.source               rsp_if
);

   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int SAW = $clog2(MAX_ENTRIES * hesm_pkg::ENTRY_BYTES);

   hesm_pkg::back_state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in, e_ff, e_in;
   logic [8:0]    add_len_ff, add_len_in, name_len_ff, name_len_in;
   logic [8:0]    rd_i_ff, rd_i_in, plen_ff, plen_in;
   logic          too_long_ff, too_long_in, pend_ff, pend_in;
   logic [7:0]    prev_ff, prev_in, first_ff, first_in, head_ff, head_in;
   hesm_pkg::outcome_type outcome_ff, outcome_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_outcome_ff, rsp_outcome_in;
   logic [4:0]    rsp_held_ff, rsp_held_in;

   logic           store_we, ring_we, meta_we;
   logic [SAW-1:0] store_waddr, store_raddr;
   logic [7:0]     store_wdata, store_rdata, ring_rdata, ring_raddr;
   logic [9:0]     meta_wdata, meta_rdata;
   logic [EW-1:0]  meta_waddr, meta_raddr;

   logic       is_pat, is_name, has_char, out_free, eligible, mismatch, hit_done;
   logic [8:0] fin_len, meta_len;
   logic       fin_suffix, fin_ok, meta_suffix;
   logic [31:0] count_wide;

   hesm_ram #(.WIDTH(8), .DEPTH(MAX_ENTRIES * hesm_pkg::ENTRY_BYTES), .ADDR_W(SAW))
      u_store (.clock(clock), .wr_en(store_we), .wr_addr(store_waddr),
               .wr_data(store_wdata), .rd_addr(store_raddr), .rd_data(store_rdata));
   hesm_ram #(.WIDTH(8), .DEPTH(hesm_pkg::RING_BYTES), .ADDR_W(8))
      u_ring (.clock(clock), .wr_en(ring_we), .wr_addr(head_ff),
              .wr_data(head.text_byte), .rd_addr(ring_raddr), .rd_data(ring_rdata));
   hesm_ram #(.WIDTH(10), .DEPTH(MAX_ENTRIES), .ADDR_W(EW))
      u_meta (.clock(clock), .wr_en(meta_we), .wr_addr(meta_waddr),
              .wr_data(meta_wdata), .rd_addr(meta_raddr), .rd_data(meta_rdata));

   assign is_pat = (head.op == hesm_pkg::OP_PAT_BYTE) || (head.op == hesm_pkg::OP_PAT_END);
   assign is_name = !is_pat;
   assign has_char = (head.text_byte != 8'h00);
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // Closing checks for a pattern: one trailing dot is dropped first.
   assign fin_suffix = (first_ff == hesm_pkg::DOT);
   assign fin_len = add_len_ff - {8'd0, (prev_ff == hesm_pkg::DOT)};
   always_comb begin
      fin_ok = 1'b1;
      if (count_ff >= CW'(MAX_ENTRIES)) fin_ok = 1'b0;
      if (too_long_ff || add_len_ff == 9'd0) fin_ok = 1'b0;
      if (fin_len <= {8'd0, fin_suffix}) fin_ok = 1'b0;
      if (fin_len - {8'd0, fin_suffix} > hesm_pkg::HOST_MAX) fin_ok = 1'b0;
   end

   assign meta_suffix = meta_rdata[9];
   assign meta_len = meta_rdata[8:0];
   assign eligible = (meta_len != 9'd0) && !meta_len[8] &&
                     (meta_suffix ? (name_len_ff > meta_len) : (name_len_ff == meta_len));
   assign mismatch = pend_ff && (ring_rdata != store_rdata);
   assign hit_done = pend_ff && !mismatch && (rd_i_ff == plen_ff);

   assign store_waddr = SAW'({count_ff[EW-1:0], add_len_ff[7:0]});
   assign store_wdata = hesm_pkg::to_lower(head.text_byte);
   assign store_raddr = SAW'({e_ff[EW-1:0], rd_i_ff[7:0]});
   assign ring_raddr = head_ff - plen_ff[7:0] + rd_i_ff[7:0];
   assign meta_waddr = count_ff[EW-1:0];
   assign meta_wdata = {fin_suffix, fin_len};
   assign meta_raddr = e_ff[EW-1:0];
   assign count_wide = 32'(count_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hesm_pkg::B_IDLE: begin
            if (head.valid) begin
               if (head.op == hesm_pkg::OP_PAT_END) state_in = hesm_pkg::B_ADD_FIN;
               else if (head.op == hesm_pkg::OP_NAME_END) state_in = hesm_pkg::B_META_RD;
            end
         end
         hesm_pkg::B_ADD_FIN: state_in = hesm_pkg::B_EMIT;
         hesm_pkg::B_META_RD: begin
            state_in = (e_ff >= count_ff) ? hesm_pkg::B_EMIT : hesm_pkg::B_META_CHK;
         end
         hesm_pkg::B_META_CHK: begin
            state_in = eligible ? hesm_pkg::B_CMP : hesm_pkg::B_META_RD;
         end
         hesm_pkg::B_CMP: begin
            if (mismatch) state_in = hesm_pkg::B_META_RD;
            else if (hit_done) state_in = hesm_pkg::B_EMIT;
         end
         hesm_pkg::B_EMIT: begin
            if (out_free) state_in = hesm_pkg::B_IDLE;
         end
         default: state_in = hesm_pkg::B_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      pop = 1'b0;
      store_we = 1'b0;
      ring_we = 1'b0;
      meta_we = 1'b0;
      count_in = count_ff;
      e_in = e_ff;
      add_len_in = add_len_ff;
      too_long_in = too_long_ff;
      prev_in = prev_ff;
      first_in = first_ff;
      head_in = head_ff;
      name_len_in = name_len_ff;
      rd_i_in = rd_i_ff;
      pend_in = pend_ff;
      plen_in = plen_ff;
      outcome_in = outcome_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_held_in = rsp_held_ff;
      case (state_ff)
         hesm_pkg::B_IDLE: begin
            pop = head.valid;
            if (head.valid && has_char) begin
               if (is_pat) begin
                  if (!add_len_ff[8]) begin
                     store_we = (count_ff < CW'(MAX_ENTRIES));
                     if (add_len_ff == 9'd0) first_in = store_wdata;
                     add_len_in = add_len_ff + 9'd1;
                  end else begin
                     too_long_in = 1'b1;
                  end
                  prev_in = head.text_byte;
               end else if (is_name) begin
                  ring_we = 1'b1;
                  head_in = head_ff + 8'd1;
                  if (!name_len_ff[8]) name_len_in = name_len_ff + 9'd1;
               end
            end
            e_in = '0;
         end
         hesm_pkg::B_ADD_FIN: begin
            meta_we = fin_ok;
            if (fin_ok) count_in = CW'(count_ff + 1'b1);
            outcome_in = fin_ok ? hesm_pkg::OUT_ADDED : hesm_pkg::OUT_REJECTED;
            add_len_in = '0;
            too_long_in = 1'b0;
            prev_in = '0;
         end
         hesm_pkg::B_META_RD: begin
            if (e_ff >= count_ff) begin
               outcome_in = hesm_pkg::OUT_MISS;
               name_len_in = '0;
               head_in = '0;
            end
         end
         hesm_pkg::B_META_CHK: begin
            plen_in = meta_len;
            rd_i_in = '0;
            pend_in = 1'b0;
            if (!eligible) e_in = CW'(e_ff + 1'b1);
         end
         hesm_pkg::B_CMP: begin
            if (mismatch) begin
               e_in = CW'(e_ff + 1'b1);
            end else if (hit_done) begin
               outcome_in = hesm_pkg::OUT_HIT;
               name_len_in = '0;
               head_in = '0;
            end else begin
               rd_i_in = rd_i_ff + 9'd1;
               pend_in = 1'b1;
            end
         end
         hesm_pkg::B_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_outcome_in = outcome_ff;
               rsp_held_in = count_wide[4:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hesm_pkg::B_IDLE;
         count_ff <= '0;
         add_len_ff <= '0;
         too_long_ff <= 1'b0;
         prev_ff <= '0;
         head_ff <= '0;
         name_len_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         add_len_ff <= add_len_in;
         too_long_ff <= too_long_in;
         prev_ff <= prev_in;
         head_ff <= head_in;
         name_len_ff <= name_len_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      first_ff <= first_in;
      e_ff <= e_in;
      rd_i_ff <= rd_i_in;
      plen_ff <= plen_in;
      outcome_ff <= outcome_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_held_ff <= rsp_held_in;
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.outcome = rsp_outcome_ff;
   assign rsp_if.entries_held = rsp_held_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES)) else $error("entry count above table size");
   a_cmp_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == hesm_pkg::B_CMP |-> rd_i_ff <= plen_ff)
      else $error("compare index ran past entry length");
   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      state_ff == hesm_pkg::B_EMIT && out_free |=> rsp_valid_ff)
      else $error("finished request produced no response");

endmodule

// File: tb/sv/tb_hesm_checker.sv
module tb_hesm_checker (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_ready,
   input  logic          req_mode,
   input  logic [7:0]    req_text_byte,
   input  logic          req_is_last,
   input  logic          rsp_valid,
   input  logic          rsp_ready,
   input  logic [1:0]    rsp_outcome,
   input  logic [4:0]    rsp_entries_held,
   output int            fail_count,
   output int            pending_count
);

   localparam int N_ENTRIES = 16;

   typedef struct packed {
      hesm_pkg::outcome_type outcome;
      logic [4:0]            entries_held;
   } verdict_type;

   logic [7:0] pat_mem [N_ENTRIES][hesm_pkg::ENTRY_BYTES];
   logic [8:0] pat_len [N_ENTRIES];
   int         n_held;
   int         add_len;
   bit         add_overflow;
   logic [7:0] add_prev;
   logic [7:0] ring [hesm_pkg::RING_BYTES];
   int         name_len;
   int         ring_head;
   verdict_type verdict_q[$];

   function automatic bit tail_hits(int e, int plen);
      int pos;
      for (int i = 0; i < plen; i++) begin
         pos = (ring_head + hesm_pkg::RING_BYTES - plen + i) % hesm_pkg::RING_BYTES;
         if (ring[pos] != pat_mem[e][i]) return 0;
      end
      return 1;
   endfunction

   function automatic bit close_pattern();
      int plen;
      int off;
      plen = add_len;
      if (n_held >= N_ENTRIES || add_overflow || plen == 0) return 0;
      if (add_prev == hesm_pkg::DOT) plen--;
      if (plen == 0) return 0;
      off = (pat_mem[n_held][0] == hesm_pkg::DOT) ? 1 : 0;
      if (off >= plen) return 0;
      if (plen - off > hesm_pkg::HOST_MAX) return 0;
      pat_len[n_held] = plen[8:0];
      n_held++;
      return 1;
   endfunction

   function automatic bit close_name();
      int plen;
      for (int e = 0; e < n_held; e++) begin
         plen = pat_len[e];
         if (plen == 0 || plen >= hesm_pkg::RING_BYTES) continue;
         if (pat_mem[e][0] == hesm_pkg::DOT) begin
            if (name_len > plen && tail_hits(e, plen)) return 1;
         end else begin
            if (name_len == plen && tail_hits(e, plen)) return 1;
         end
      end
      return 0;
   endfunction

   task automatic absorb_request(logic m, logic [7:0] c, logic last);
      verdict_type v;
      if (m == 1'b0) begin
         if (c != 8'h00) begin
            if (add_len < hesm_pkg::ENTRY_BYTES) begin
               if (n_held < N_ENTRIES) begin
                  pat_mem[n_held][add_len] = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
               end
               add_len++;
            end else begin
               add_overflow = 1;
            end
            add_prev = c;
         end
         if (last) begin
            v.outcome = close_pattern() ? hesm_pkg::OUT_ADDED : hesm_pkg::OUT_REJECTED;
            v.entries_held = n_held[4:0];
            verdict_q.push_back(v);
            add_len = 0;
            add_overflow = 0;
            add_prev = 8'h00;
         end
      end else begin
         if (c != 8'h00) begin
            ring[ring_head] = c;
            ring_head = (ring_head + 1) % hesm_pkg::RING_BYTES;
            if (name_len < hesm_pkg::RING_BYTES) name_len++;
         end
         if (last) begin
            v.outcome = close_name() ? hesm_pkg::OUT_HIT : hesm_pkg::OUT_MISS;
            v.entries_held = n_held[4:0];
            verdict_q.push_back(v);
            name_len = 0;
            ring_head = 0;
         end
      end
   endtask

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         n_held = 0;
         add_len = 0;
         add_overflow = 0;
         add_prev = 8'h00;
         name_len = 0;
         ring_head = 0;
         fail_count = 0;
         verdict_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("Unexpected response: outcome %0d entries %0d",
                     rsp_outcome, rsp_entries_held);
               end
            end else begin
               want = verdict_q.pop_front();
               if (rsp_outcome !== want.outcome
                   || rsp_entries_held !== want.entries_held) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("Response mismatch: expected outcome %0d entries %0d, got %0d %0d",
                        want.outcome, want.entries_held, rsp_outcome, rsp_entries_held);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            absorb_request(req_mode, req_text_byte, req_is_last);
         end
      end
      pending_count = verdict_q.size();
   end
endmodule

// File: tb/sv/tb_host_exact_suffix_matcher_unit.sv
module tb_host_exact_suffix_matcher_unit;

   // Bounded by the slowest name walk (16 entries of 254 bytes) plus stalls.
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hesm_req_if req_ch();
   hesm_rsp_if rsp_ch();

   int  fail_count;
   int  pending_count;
   int  send_idle_pct = 34;
   int  recv_idle_pct = 54;
   bit  hold_off = 0;
   int  quiet_cycles = 0;
   bit  stimulus_done = 0;

   // The pattern and name templates that the random part draws on.
   logic [7:0] host_pool [8][$];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   host_exact_suffix_matcher_unit uut (
      .clock(clock),
      .reset(reset),
      .req_if(req_ch.sink),
      .rsp_if(rsp_ch.source)
   );

   tb_hesm_checker scoreboard (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready),
      .req_mode(req_ch.mode), .req_text_byte(req_ch.text_byte),
      .req_is_last(req_ch.is_last),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
      .rsp_outcome(rsp_ch.outcome), .rsp_entries_held(rsp_ch.entries_held),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      req_ch.valid = 1'b0;
      req_ch.mode = 1'b0;
      req_ch.text_byte = 8'h00;
      req_ch.is_last = 1'b0;
      rsp_ch.ready = 1'b0;
   end

   // The receiver idles at random, except during a forced long hold-off.
   always @(posedge clock) begin
      if (reset || hold_off) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // The watchdog counts cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (!stimulus_done || pending_count != 0) begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Offers one request, holding it until the block takes it. A random idle
   // gap may come before the offer.
   task automatic send_request(logic m, logic [7:0] c, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode <= m;
      req_ch.text_byte <= c;
      req_ch.is_last <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic send_string(logic m, logic [7:0] s[$]);
      for (int i = 0; i < s.size(); i++) begin
         send_request(m, s[i], i == s.size() - 1);
      end
   endtask

   // Builds a random host name of lowercase letters, digits and dots.
   function automatic void make_host(output logic [7:0] s[$], input int len);
      s = {};
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(5))
            0: s.push_back(8'h2E);
            1: s.push_back(8'h30 + 8'($urandom_range(2)));
            default: s.push_back(8'h61 + 8'($urandom_range(3)));
         endcase
      end
   endfunction

   function automatic void fill_bytes(output logic [7:0] s[$], input int len,
                                      input logic [7:0] c);
      s = {};
      for (int i = 0; i < len; i++) s.push_back(c);
   endfunction

   // Lets the block finish its backlog so the next phase starts clean.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      logic [7:0] s[$];
      logic [7:0] t[$];
      logic [7:0] nm[$];
      int pick;
      int sent;
      bit pressed;
      pressed = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: the special cases of patterns and names.
      send_request(1'b1, 8'h61, 1'b1);                   // Name against an empty table.
      send_request(1'b0, 8'h00, 1'b1);                   // Empty pattern is rejected.
      s = {8'h2E}; send_string(1'b0, s);                 // Only the dot marker.
      s = {8'h2E, 8'h2E}; send_string(1'b0, s);          // Marker plus trailing dot.
      s = {8'h41, 8'h00, 8'h5A, 8'h2E}; send_string(1'b0, s);  // "AZ." becomes "az".
      s = {8'h2E, 8'h62, 8'hFF}; send_string(1'b0, s);   // Suffix entry ".b\xff".
      s = {8'h61, 8'h7A}; send_string(1'b1, s);          // Exact hit.
      s = {8'h61, 8'h7A, 8'h7A}; send_string(1'b1, s);   // Exact miss.
      s = {8'h78, 8'h2E, 8'h62, 8'hFF}; send_string(1'b1, s);  // Suffix hit.
      s = {8'h2E, 8'h62, 8'hFF}; send_string(1'b1, s);   // Equal length is no suffix hit.
      s = {8'h61, 8'h00}; send_string(1'b1, s);          // Zero byte closes the name.
      // Mixed modes interleaved within one string.
      send_request(1'b0, 8'h71, 1'b0);
      send_request(1'b1, 8'h71, 1'b1);
      send_request(1'b0, 8'h80, 1'b1);
      fill_bytes(s, 253, 8'h6B); send_string(1'b0, s);   // Longest host part.
      fill_bytes(s, 254, 8'h6B); send_string(1'b0, s);   // One too long.
      fill_bytes(s, 257, 8'h6B); send_string(1'b0, s);   // Past the store.
      fill_bytes(s, 257, 8'h6B); send_string(1'b1, s);   // Long name, length saturates.
      drain();

      // Random part in three idling phases. The table is not cleared between
      // phases, so it fills early and later patterns are mostly rejected.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 54 : 0;
         recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 34 : 0;
         for (int k = 0; k < 8; k++) make_host(host_pool[k], $urandom_range(1, 6));
         sent = 0;
         while (sent < 100) begin
            pick = $urandom_range(7);
            case ($urandom_range(9))
               0, 1: begin
                  s = host_pool[pick];
                  if ($urandom_range(1)) s.push_front(8'h2E);
                  if ($urandom_range(3) == 0) s.push_back(8'h2E);
                  for (int i = 0; i < s.size(); i++) begin
                     if ($urandom_range(3) == 0 && s[i] >= 8'h61 && s[i] <= 8'h7A) begin
                        s[i] = s[i] - 8'h20;
                     end
                  end
                  send_string(1'b0, s);
               end
               2: begin
                  s = {};
                  for (int i = $urandom_range(1, 4); i > 0; i--) begin
                     s.push_back(8'($urandom_range(255)));
                  end
                  send_string(1'($urandom_range(1)), s);
               end
               default: begin
                  make_host(t, $urandom_range(0, 3));
                  nm = t;
                  if ($urandom_range(1)) nm.push_back(8'h2E);
                  foreach (host_pool[pick][i]) nm.push_back(host_pool[pick][i]);
                  if ($urandom_range(4) == 0) nm.push_back(8'h00);
                  s = nm;
                  send_string(1'b1, s);
               end
            endcase
            sent += s.size();
            if (phase == 2 && !pressed && sent > 50) begin
               // Long receiver hold-off while requests keep coming.
               pressed = 1;
               fork
                  begin
                     hold_off = 1;
                     repeat (300) @(posedge clock);
                     hold_off = 0;
                  end
               join_none
               for (int i = 0; i < 12; i++) begin
                  s = {8'h61, 8'h62};
                  send_string(1'b1, s);
               end
               wait fork;
               sent += 24;
            end
         end
         drain();
      end

      req_ch.valid <= 1'b0;
      stimulus_done = 1;
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

// File: filelist.f
hdl/hesm_pkg.sv
hdl/hesm_if.sv
hdl/hesm_ram.sv
hdl/hesm_front.sv
hdl/hesm_back.sv
hdl/host_exact_suffix_matcher_unit.sv
tb/sv/tb_hesm_checker.sv
tb/sv/tb_host_exact_suffix_matcher_unit.sv
